/* hw/rtl/stereo_gap_filter_biquad_chain_unit_defines.svh */
`ifndef STEREO_GAP_FILTER_BIQUAD_CHAIN_UNIT_DEFINES_SVH
`define STEREO_GAP_FILTER_BIQUAD_CHAIN_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SGF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SGF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SGF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/sgfbq_pkg.sv */
package sgfbq_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 32;
    localparam int SIG_W            = 32;
    localparam int GAIN_W           = 18;
    localparam int GAIN_FRAC        = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int MEM_DEPTH        = 32;
    localparam int MEM_AW           = 5;
    localparam int STEP_W           = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HP_TO_LP = 3'd0,
        REG_IN_TO_LP = 3'd1,
        REG_LP_OUT   = 3'd2,
        REG_HP_OUT   = 3'd3,
        REG_IN_OUT   = 3'd4
    } cfg_reg_t;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    localparam logic signed [GAIN_W-1:0] IN_OUT_GAIN_RST = 18'sd65536;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RD     = 8'b0000_0010,
        ST_MAC    = 8'b0000_0100,
        ST_RND    = 8'b0000_1000,
        ST_WB     = 8'b0001_0000,
        ST_MIX    = 8'b0010_0000,
        ST_MIXRND = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
        logic mix;
    } mac_ctrl_t;

endpackage

/* hw/rtl/sgfbq_mac.sv */
module sgfbq_mac #(
    parameter int COEF_WIDTH = sgfbq_pkg::COEF_WIDTH_DEF
) (
    input  logic                                              aclk,
    input  sgfbq_pkg::mac_ctrl_t                              ctrl,
    input  logic signed [sgfbq_pkg::SIG_W-1:0]                op_a,
    input  logic signed [COEF_WIDTH-1:0]                      op_b,
    output logic signed [sgfbq_pkg::SIG_W+COEF_WIDTH+2:0]     rnd
);
    import sgfbq_pkg::*;

    localparam int PROD_W = SIG_W + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + 3;
    localparam int BQ_SH  = COEF_WIDTH - 4;
    localparam logic signed [ACC_W-1:0] HALF_BQ  = ACC_W'(1) <<< (BQ_SH - 1);
    localparam logic signed [ACC_W-1:0] HALF_MIX = ACC_W'(1) <<< (GAIN_FRAC - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign rnd = ctrl.mix ? ((acc_reg + HALF_MIX) >>> GAIN_FRAC)
                          : ((acc_reg + HALF_BQ) >>> BQ_SH);

endmodule

/* hw/rtl/stereo_gap_filter_biquad_chain_unit.sv */
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | tuser: kind; tdata: left_in, right_in, coef_index,
//         |     |                    |        coef_value
// m_      | out | m_tvalid/m_tready  | tdata: left_out, right_out
// cfg_    | in  | cfg_we             | cfg_addr, cfg_wdata (5 gain registers)
// A coefficient write goes straight into the coefficient memory when accepted. A sample pair
// runs through eight biquads (read, multiply-accumulate on the shared multiplier, round,
// write-back) and four gain mixes, all through the single MAC and history memory port.
// Reset restores the gains and clears the output valid flag and the memory valid bits.
// The finished pair waits in the output register; the next item is taken meanwhile.
// A full output register holds the next finished pair in ST_DONE with s_tready low.
`include "stereo_gap_filter_biquad_chain_unit_defines.svh"

module stereo_gap_filter_biquad_chain_unit #(
    parameter int SAMPLE_WIDTH = sgfbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = sgfbq_pkg::COEF_WIDTH_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    // left_in, right_in, coef_index, coef_value, zero fill
    input  logic [((2*SAMPLE_WIDTH+5+COEF_WIDTH+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic                                            s_tuser,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    // left_out, right_out, zero fill
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]              m_tdata,
    input  logic                                            cfg_we,
    input  logic [sgfbq_pkg::CFG_IDX_W-1:0]                 cfg_addr,
    input  logic [sgfbq_pkg::GAIN_W-1:0]                    cfg_wdata
);
    import sgfbq_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COEF_WIDTH;
    localparam int ACC_W  = SIG_W + CW + 3;
    localparam int M_W    = ((2*SW+7)/8)*8;

    logic signed [SW-1:0]   left_in, right_in;
    logic [MEM_AW-1:0]      coef_index;
    logic signed [CW-1:0]   coef_value;

    assign left_in    = s_tdata[SW-1:0];
    assign right_in   = s_tdata[2*SW-1:SW];
    assign coef_index = s_tdata[2*SW+MEM_AW-1:2*SW];
    assign coef_value = s_tdata[2*SW+MEM_AW+CW-1:2*SW+MEM_AW];

    state_t state_reg, state_next;
    logic                   side_reg, side_next;
    logic [1:0]             stage_reg, stage_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic signed [SIG_W-1:0] x_reg, x_next;
    logic signed [SIG_W-1:0] y_reg, y_next;
    logic signed [SIG_W-1:0] hp_reg, hp_next;
    logic signed [SIG_W-1:0] in_l_reg, in_l_next;
    logic signed [SIG_W-1:0] in_r_reg, in_r_next;
    logic signed [SW-1:0]   res_l_reg, res_l_next;
    logic signed [SW-1:0]   res_r_reg, res_r_next;
    logic signed [SW-1:0]   m_l_reg, m_l_next;
    logic signed [SW-1:0]   m_r_reg, m_r_next;
    logic                   m_valid_reg, m_valid_next;
    logic signed [CW-1:0]   c_reg [4];
    logic signed [CW-1:0]   c_next [4];
    logic signed [SIG_W-1:0] h_reg [4];
    logic signed [SIG_W-1:0] h_next [4];
    logic signed [GAIN_W-1:0] g_reg [5];
    logic [MEM_DEPTH-1:0]   coef_vld_reg, coef_vld_next;
    logic [MEM_DEPTH-1:0]   hist_vld_reg, hist_vld_next;

    logic signed [CW-1:0]    coef_mem [MEM_DEPTH];
    logic signed [SIG_W-1:0] hist_mem [MEM_DEPTH];
    logic signed [CW-1:0]    coef_q_reg;
    logic                    coef_qv_reg;
    logic signed [SIG_W-1:0] hist_q_reg;
    logic                    hist_qv_reg;

    logic [MEM_AW-1:0]       mem_addr;
    logic                    rd_en, hist_we, coef_we, in_acc;
    logic signed [SIG_W-1:0] hist_wdata;
    logic signed [CW-1:0]    coef_eff;
    logic signed [SIG_W-1:0] hist_eff, in_side;

    mac_ctrl_t               mac_ctrl;
    logic signed [SIG_W-1:0] op_a;
    logic signed [CW-1:0]    op_b;
    logic signed [ACC_W-1:0] rnd;
    logic [ACC_W-SIG_W:0]    hi32;
    logic [ACC_W-SW:0]       hisw;
    logic signed [SIG_W-1:0] sat32;
    logic signed [SW-1:0]    satsw;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign coef_we    = in_acc && (s_tuser == KIND_COEF);
    assign mem_addr   = {side_reg, stage_reg, step_reg[1:0]};
    assign rd_en      = (state_reg == ST_RD) && (step_reg < 3'd4);
    assign hist_we    = (state_reg == ST_WB);
    assign coef_eff   = coef_qv_reg ? coef_q_reg : '0;
    assign hist_eff   = hist_qv_reg ? hist_q_reg : '0;
    assign in_side    = side_reg ? in_r_reg : in_l_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_W'({m_r_reg, m_l_reg});

    always_comb begin
        unique case (step_reg[1:0])
            2'd0:    hist_wdata = x_reg;
            2'd1:    hist_wdata = h_reg[0];
            2'd2:    hist_wdata = y_reg;
            default: hist_wdata = h_reg[2];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_index] <= coef_value;
        end
        if (hist_we) begin
            hist_mem[mem_addr] <= hist_wdata;
        end
        if (rd_en) begin
            coef_q_reg  <= coef_mem[mem_addr];
            coef_qv_reg <= coef_vld_reg[mem_addr];
            hist_q_reg  <= hist_mem[mem_addr];
            hist_qv_reg <= hist_vld_reg[mem_addr];
        end
    end

    always_comb begin
        mac_ctrl = '0;
        op_a     = '0;
        op_b     = '0;
        if (state_reg == ST_MAC) begin
            mac_ctrl.clr    = (step_reg == 3'd0);
            mac_ctrl.acc_en = (step_reg != 3'd0);
            mac_ctrl.mul_en = (step_reg < 3'd5);
            case (step_reg)
                3'd0:    begin op_a = x_reg;    op_b = c_reg[0]; end
                3'd1:    begin op_a = h_reg[0]; op_b = c_reg[1]; end
                3'd2:    begin op_a = h_reg[1]; op_b = c_reg[0]; end
                3'd3:    begin op_a = h_reg[2]; op_b = c_reg[2]; end
                default: begin op_a = h_reg[3]; op_b = c_reg[3]; end
            endcase
        end else if (state_reg == ST_MIX) begin
            mac_ctrl.mix    = 1'b1;
            mac_ctrl.clr    = (step_reg == 3'd0);
            mac_ctrl.acc_en = (step_reg != 3'd0);
            mac_ctrl.mul_en = (step_reg < 3'd3);
            if (stage_reg == 2'd1) begin
                case (step_reg)
                    3'd0:    begin op_a = hp_reg;  op_b = CW'(g_reg[REG_HP_TO_LP]); end
                    3'd1:    begin op_a = in_side; op_b = CW'(g_reg[REG_IN_TO_LP]); end
                    default: begin op_a = '0;      op_b = '0; end
                endcase
            end else begin
                case (step_reg)
                    3'd0:    begin op_a = hp_reg;  op_b = CW'(g_reg[REG_HP_OUT]); end
                    3'd1:    begin op_a = y_reg;   op_b = CW'(g_reg[REG_LP_OUT]); end
                    default: begin op_a = in_side; op_b = CW'(g_reg[REG_IN_OUT]); end
                endcase
            end
        end else if (state_reg == ST_MIXRND) begin
            mac_ctrl.mix = 1'b1;
        end
    end

    sgfbq_mac #(
        .COEF_WIDTH (CW)
    ) u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .rnd  (rnd)
    );

    assign hi32  = rnd[ACC_W-1:SIG_W-1];
    assign hisw  = rnd[ACC_W-1:SW-1];
    assign sat32 = ((&hi32) || !(|hi32)) ? rnd[SIG_W-1:0]
                 : (rnd[ACC_W-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}});
    assign satsw = ((&hisw) || !(|hisw)) ? rnd[SW-1:0]
                 : (rnd[ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

    always_comb begin
        state_next    = state_reg;
        side_next     = side_reg;
        stage_next    = stage_reg;
        step_next     = step_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        hp_next       = hp_reg;
        in_l_next     = in_l_reg;
        in_r_next     = in_r_reg;
        res_l_next    = res_l_reg;
        res_r_next    = res_r_reg;
        m_l_next      = m_l_reg;
        m_r_next      = m_r_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        c_next        = c_reg;
        h_next        = h_reg;
        coef_vld_next = coef_vld_reg;
        hist_vld_next = hist_vld_reg;
        if (coef_we) begin
            coef_vld_next[coef_index] = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && (s_tuser == KIND_SAMPLE)) begin
                    in_l_next  = SIG_W'(left_in);
                    in_r_next  = SIG_W'(right_in);
                    x_next     = SIG_W'(left_in);
                    side_next  = 1'b0;
                    stage_next = 2'd0;
                    step_next  = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                case (step_reg)
                    3'd1:    begin c_next[0] = coef_eff; h_next[0] = hist_eff; end
                    3'd2:    begin c_next[1] = coef_eff; h_next[1] = hist_eff; end
                    3'd3:    begin c_next[2] = coef_eff; h_next[2] = hist_eff; end
                    3'd4:    begin c_next[3] = coef_eff; h_next[3] = hist_eff; end
                    default: ;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5) begin
                    step_next  = '0;
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                y_next     = sat32;
                state_next = ST_WB;
            end
            ST_WB: begin
                hist_vld_next[mem_addr] = 1'b1;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) begin
                    step_next = '0;
                    x_next    = y_reg;
                    if (stage_reg == 2'd1) begin
                        hp_next    = y_reg;
                        state_next = ST_MIX;
                    end else if (stage_reg == 2'd3) begin
                        state_next = ST_MIX;
                    end else begin
                        stage_next = stage_reg + 2'd1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_MIX: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) begin
                    step_next  = '0;
                    state_next = ST_MIXRND;
                end
            end
            ST_MIXRND: begin
                if (stage_reg == 2'd1) begin
                    x_next     = sat32;
                    stage_next = 2'd2;
                    state_next = ST_RD;
                end else if (!side_reg) begin
                    res_l_next = satsw;
                    x_next     = in_r_reg;
                    side_next  = 1'b1;
                    stage_next = 2'd0;
                    state_next = ST_RD;
                end else begin
                    res_r_next = satsw;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_l_next     = res_l_reg;
                    m_r_next     = res_r_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            side_reg     <= 1'b0;
            stage_reg    <= '0;
            step_reg     <= '0;
            m_valid_reg  <= 1'b0;
            coef_vld_reg <= '0;
            hist_vld_reg <= '0;
        end else begin
            state_reg    <= state_next;
            side_reg     <= side_next;
            stage_reg    <= stage_next;
            step_reg     <= step_next;
            m_valid_reg  <= m_valid_next;
            coef_vld_reg <= coef_vld_next;
            hist_vld_reg <= hist_vld_next;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        hp_reg    <= hp_next;
        in_l_reg  <= in_l_next;
        in_r_reg  <= in_r_next;
        res_l_reg <= res_l_next;
        res_r_reg <= res_r_next;
        m_l_reg   <= m_l_next;
        m_r_reg   <= m_r_next;
        c_reg     <= c_next;
        h_reg     <= h_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_reg[REG_HP_TO_LP] <= '0;
            g_reg[REG_IN_TO_LP] <= '0;
            g_reg[REG_LP_OUT]   <= '0;
            g_reg[REG_HP_OUT]   <= '0;
            g_reg[REG_IN_OUT]   <= IN_OUT_GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_HP_TO_LP: g_reg[REG_HP_TO_LP] <= cfg_wdata;
                REG_IN_TO_LP: g_reg[REG_IN_TO_LP] <= cfg_wdata;
                REG_LP_OUT:   g_reg[REG_LP_OUT]   <= cfg_wdata;
                REG_HP_OUT:   g_reg[REG_HP_OUT]   <= cfg_wdata;
                REG_IN_OUT:   g_reg[REG_IN_OUT]   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    `SGF_ASSERT(a_hist_wr_only_wb, aclk, aresetn, hist_we |-> (step_reg < 3'd4), "history write step out of range")
    `SGF_ASSERT(a_done_loads_out, aclk, aresetn, (state_reg == ST_DONE && (!m_valid_reg || m_tready)) |=> (m_tvalid && state_reg == ST_IDLE), "finished pair not presented")
    `SGF_ASSERT(a_sample_starts, aclk, aresetn, (in_acc && s_tuser == KIND_SAMPLE) |=> (state_reg == ST_RD && !side_reg && stage_reg == 2'd0 && step_reg == '0), "sample did not start left chain")
    `SGF_ASSERT(a_coef_idle_only, aclk, aresetn, coef_we |-> (state_reg == ST_IDLE && !rd_en && !hist_we), "coefficient write outside idle")

endmodule
